// ===== hdl/prt_pkg.sv =====
// shared constants, codes and types of the packet receive tracker
package prt_pkg;

  localparam int MAX_PACKETS = 4096;
  localparam int IDX_W       = $clog2(MAX_PACKETS);
  localparam int LINK_W      = $clog2(MAX_PACKETS + 1);
  localparam logic [LINK_W-1:0] END_LINK = LINK_W'(MAX_PACKETS);

  localparam int DIV_W  = 32;
  localparam int DSR_W  = 16;
  localparam int CNT_W  = $clog2(DIV_W);
  localparam logic [6:0] PERCENT = 7'd100;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_START  = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_BAD_COUNT  = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_PACKET_BYTES = 1'd0,
    REG_FILE_BYTES   = 1'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_MARK,
    OP_PROGRESS
  } div_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIVDONE,
    S_FILL,
    S_QREAD,
    S_MREAD,
    S_MLINK,
    S_RESULT
  } state_t;

endpackage

// ===== hdl/prt_ram.sv =====
// generic single-port ram with registered read
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/packet_receive_tracker.sv =====
// packet receive tracker: outstanding packet list held in two link memories
// per mode: other registers its result directly, query reads the next link memory,
//   start divides then fills one packet per cycle, mark runs up to two 32-step
//   divisions in one shared divider; one item at a time, the next one taken the
//   cycle after a result is registered, and a waiting result holds
// reset: control state and list registers clear at once; link memories need no
//   clearing pass, every entry below the packet count is written by start
module packet_receive_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // byte_offset[31:0], entry_index[43:32], zero pad
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // newly_received[0], link_index[13:1], head_index[26:14],
  // outstanding_count[39:27], progress_percent[46:40], all_received[47]
  output logic [47:0] m_tdata,
  output logic [2:0]  m_tuser    // status
);

  localparam int IW = prt_pkg::IDX_W;
  localparam int LW = prt_pkg::LINK_W;

  // configuration registers
  logic [15:0] packet_bytes;
  logic [31:0] file_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_bytes <= 16'd1024;
      file_bytes   <= '0;
    end else if (cfg_we) begin
      unique case (prt_pkg::reg_index_t'(cfg_index))
        prt_pkg::REG_PACKET_BYTES: packet_bytes <= cfg_data[15:0];
        prt_pkg::REG_FILE_BYTES:   file_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  prt_pkg::state_t state, state_next;
  prt_pkg::div_op_t div_op;

  // list state
  logic [LW-1:0] list_head, pending, total;
  logic          started;
  logic [6:0]    progress;

  // item and result
  logic [IW-1:0]       idx;
  logic [LW-1:0]       nx, pv;
  prt_pkg::status_t    res_status;
  prt_pkg::status_t    in_status;
  logic                res_fresh;
  logic [LW-1:0]       res_link;
  logic [IW-1:0]       fill_idx;

  // bit-serial divider
  logic [prt_pkg::DIV_W-1:0] div_q;
  logic [prt_pkg::DSR_W-1:0] div_r, div_d;
  logic [prt_pkg::CNT_W-1:0] div_cnt;
  logic [prt_pkg::DSR_W:0]   div_trial;
  logic                      div_ge;
  logic [prt_pkg::DIV_W:0]   count;
  logic                      count_bad;

  // memory ports
  logic          p_we, n_we;
  logic [IW-1:0] p_addr, n_addr;
  logic [LW-1:0] p_wdata, n_wdata, p_rdata, n_rdata;

  logic [IW-1:0]       in_eidx;
  prt_pkg::mode_t      in_mode;
  logic                accept, out_free, fill_last;
  logic [19:0]         prog_num;

  assign in_eidx   = s_tdata[43:32];
  assign in_mode   = prt_pkg::mode_t'(s_tuser);
  assign s_tready  = (state == prt_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign fill_last = ({1'b0, fill_idx} == total - LW'(1));

  assign div_trial = {div_r, div_q[prt_pkg::DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_d});
  // ceiling of file size over packet size
  assign count     = {1'b0, div_q} + {{prt_pkg::DIV_W{1'b0}}, (div_r != '0)};
  assign count_bad = (count == '0) || (count > (prt_pkg::DIV_W+1)'(prt_pkg::MAX_PACKETS));
  // received packets times 100, counting the one being removed now
  assign prog_num  = 20'(total - pending + LW'(1)) * 20'(prt_pkg::PERCENT);

  // status decided at intake
  always_comb begin
    in_status = prt_pkg::ST_OK;
    unique case (in_mode)
      prt_pkg::MODE_START: begin
        if (packet_bytes == '0) in_status = prt_pkg::ST_BAD_COUNT;
      end
      prt_pkg::MODE_MARK: begin
        if (!started)                in_status = prt_pkg::ST_NOT_START;
        else if (packet_bytes == '0) in_status = prt_pkg::ST_MISALIGNED;
      end
      prt_pkg::MODE_QUERY: begin
        if (!started)                      in_status = prt_pkg::ST_NOT_START;
        else if ({1'b0, in_eidx} >= total) in_status = prt_pkg::ST_RANGE;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      prt_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            prt_pkg::MODE_START:
              state_next = (packet_bytes == '0) ? prt_pkg::S_RESULT : prt_pkg::S_DIV;
            prt_pkg::MODE_MARK:
              state_next = (!started || packet_bytes == '0) ? prt_pkg::S_RESULT
                                                            : prt_pkg::S_DIV;
            prt_pkg::MODE_QUERY:
              state_next = (!started || {1'b0, in_eidx} >= total) ? prt_pkg::S_RESULT
                                                                  : prt_pkg::S_QREAD;
            default: state_next = prt_pkg::S_RESULT;
          endcase
        end
      end
      prt_pkg::S_DIV: if (div_cnt == '0) state_next = prt_pkg::S_DIVDONE;
      prt_pkg::S_DIVDONE: begin
        unique case (div_op)
          prt_pkg::OP_START:
            state_next = count_bad ? prt_pkg::S_RESULT : prt_pkg::S_FILL;
          prt_pkg::OP_MARK:
            state_next = (div_r != '0 || div_q >= prt_pkg::DIV_W'(total))
                         ? prt_pkg::S_RESULT : prt_pkg::S_MREAD;
          default: state_next = prt_pkg::S_RESULT;
        endcase
      end
      prt_pkg::S_FILL:  if (fill_last) state_next = prt_pkg::S_RESULT;
      prt_pkg::S_QREAD: state_next = prt_pkg::S_RESULT;
      prt_pkg::S_MREAD: state_next = (n_rdata == '0) ? prt_pkg::S_RESULT : prt_pkg::S_MLINK;
      prt_pkg::S_MLINK: state_next = prt_pkg::S_DIV;
      prt_pkg::S_RESULT: if (out_free) state_next = prt_pkg::S_IDLE;
      default: state_next = prt_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    p_we = 1'b0;  n_we = 1'b0;
    p_addr = in_eidx;  n_addr = in_eidx;
    p_wdata = '0;  n_wdata = '0;
    unique case (state)
      prt_pkg::S_DIVDONE: begin
        p_addr = div_q[IW-1:0];
        n_addr = div_q[IW-1:0];
      end
      prt_pkg::S_FILL: begin
        p_we = 1'b1;  n_we = 1'b1;
        p_addr = fill_idx;  n_addr = fill_idx;
        p_wdata = (fill_idx == '0) ? prt_pkg::END_LINK : {1'b0, fill_idx} - LW'(1);
        n_wdata = fill_last ? prt_pkg::END_LINK : {1'b0, fill_idx} + LW'(1);
      end
      prt_pkg::S_MREAD: begin
        // clear both links of the received entry
        p_addr = idx;  n_addr = idx;
        p_we = (n_rdata != '0);  n_we = (n_rdata != '0);
      end
      prt_pkg::S_MLINK: begin
        // splice neighbours together
        p_addr = nx[IW-1:0];  p_we = (nx < total);  p_wdata = pv;
        n_addr = pv[IW-1:0];  n_we = (pv < total);  n_wdata = nx;
      end
      default: ;
    endcase
  end

  prt_ram #(.WIDTH(LW), .DEPTH(prt_pkg::MAX_PACKETS)) u_prev (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );

  prt_ram #(.WIDTH(LW), .DEPTH(prt_pkg::MAX_PACKETS)) u_next (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
  );

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prt_pkg::S_IDLE;
      list_head <= '0;
      pending   <= '0;
      total     <= '0;
      started   <= 1'b0;
      progress  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      // result valid rises when registered and falls once taken
      if (state == prt_pkg::S_RESULT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)                          m_tvalid <= 1'b0;
      unique case (state)
        prt_pkg::S_IDLE: begin
          res_status <= in_status;
          res_fresh  <= 1'b0;
          res_link   <= prt_pkg::END_LINK;
          div_cnt    <= prt_pkg::CNT_W'(prt_pkg::DIV_W - 1);
          div_r      <= '0;
          div_d      <= packet_bytes;
          if (accept) begin
            unique case (in_mode)
              prt_pkg::MODE_START: begin
                div_op <= prt_pkg::OP_START;
                div_q  <= file_bytes;
                if (packet_bytes == '0) begin
                  list_head  <= prt_pkg::END_LINK;
                  pending    <= '0;
                  total      <= '0;
                  started    <= 1'b0;
                  progress   <= '0;
                end
              end
              prt_pkg::MODE_MARK: begin
                div_op <= prt_pkg::OP_MARK;
                div_q  <= s_tdata[31:0];
              end
              default: ;
            endcase
          end
        end
        prt_pkg::S_DIV: begin
          div_cnt <= div_cnt - prt_pkg::CNT_W'(1);
          div_q   <= {div_q[prt_pkg::DIV_W-2:0], div_ge};
          div_r   <= div_ge ? prt_pkg::DSR_W'(div_trial - {1'b0, div_d})
                            : div_trial[prt_pkg::DSR_W-1:0];
        end
        prt_pkg::S_DIVDONE: begin
          fill_idx <= '0;
          idx      <= div_q[IW-1:0];
          unique case (div_op)
            prt_pkg::OP_START: begin
              started  <= !count_bad;
              progress <= '0;
              if (count_bad) begin
                res_status <= prt_pkg::ST_BAD_COUNT;
                list_head  <= prt_pkg::END_LINK;
                pending    <= '0;
                total      <= '0;
              end else begin
                list_head <= '0;
                pending   <= count[LW-1:0];
                total     <= count[LW-1:0];
              end
            end
            prt_pkg::OP_MARK: begin
              if (div_r != '0)                          res_status <= prt_pkg::ST_MISALIGNED;
              else if (div_q >= prt_pkg::DIV_W'(total)) res_status <= prt_pkg::ST_RANGE;
            end
            default: progress <= div_q[6:0];
          endcase
        end
        prt_pkg::S_FILL:  fill_idx <= fill_idx + IW'(1);
        prt_pkg::S_QREAD: res_link <= n_rdata;
        prt_pkg::S_MREAD: begin
          nx <= n_rdata;
          pv <= p_rdata;
        end
        prt_pkg::S_MLINK: begin
          if (pv >= total) list_head <= nx;
          if (pending != '0) pending <= pending - LW'(1);
          res_fresh <= 1'b1;
          div_op    <= prt_pkg::OP_PROGRESS;
          div_q     <= prt_pkg::DIV_W'(prog_num);
          div_d     <= prt_pkg::DSR_W'(total);
          div_r     <= '0;
          div_cnt   <= prt_pkg::CNT_W'(prt_pkg::DIV_W - 1);
        end
        prt_pkg::S_RESULT: begin
          if (out_free) begin
            m_tuser  <= res_status;
            m_tdata  <= {(pending == '0), progress, pending, list_head, res_link, res_fresh};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/prt_checker.sv =====
// port-level checker for the packet receive tracker, with its bind
module prt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // empty flag agrees with the outstanding count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[47] == (m_tdata[39:27] == 13'd0)))
    else $error("all_received disagrees with outstanding_count");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[46:40] <= 7'd100)
    else $error("progress above 100");

  // a failed item never reports a new packet
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != prt_pkg::ST_OK |-> !m_tdata[0])
    else $error("newly_received on failed item");

  // one item at a time: no intake straight after an intake
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

endmodule

bind packet_receive_tracker prt_checker u_prt_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== bench/testbench.sv =====
// testbench for the packet receive tracker: directed and random stimulus checked against an in-bench model
`timescale 1ns / 100ps

module testbench;

  // one result item as the block reports it
  typedef struct {
    prt_pkg::status_t status;
    logic        fresh;
    logic [12:0] link;
    logic [12:0] head;
    logic [12:0] pending;
    logic [6:0]  percent;
    logic        done;
  } tracker_result_t;

  // list model and queue of expected results
  class tracker_scoreboard;
    logic [15:0]     pkt_bytes;
    logic [31:0]     file_len;
    logic [12:0]     prv[prt_pkg::MAX_PACKETS];
    logic [12:0]     nxt[prt_pkg::MAX_PACKETS];
    logic [12:0]     head;
    logic [12:0]     pending;
    logic [12:0]     total;
    bit              live;
    tracker_result_t awaited[$];
    int              errors;

    function new();
      pkt_bytes = 16'd1024;
      file_len  = '0;
      head      = '0;
      pending   = '0;
      total     = '0;
      live      = 0;
      errors    = 0;
    endfunction

    function void write_reg(prt_pkg::reg_index_t idx, logic [31:0] value);
      if (idx == prt_pkg::REG_PACKET_BYTES) pkt_bytes = value[15:0];
      else file_len = value;
    endfunction

    function void drop_list();
      head    = prt_pkg::END_LINK;
      pending = '0;
      total   = '0;
      live    = 0;
    endfunction

    // works out the result of one accepted item and queues it
    function void note_item(prt_pkg::mode_t md, logic [31:0] off, logic [11:0] eidx);
      tracker_result_t r;
      longint unsigned cnt;
      logic [31:0] slot;
      logic [12:0] nx, pv;
      r.status = prt_pkg::ST_OK;
      r.fresh  = 0;
      r.link   = prt_pkg::END_LINK;
      case (md)
        prt_pkg::MODE_START: begin
          if (pkt_bytes == 0) begin
            drop_list();
            r.status = prt_pkg::ST_BAD_COUNT;
          end else begin
            cnt = (longint'(file_len) + pkt_bytes - 1) / pkt_bytes;
            if (cnt == 0 || cnt > prt_pkg::MAX_PACKETS) begin
              drop_list();
              r.status = prt_pkg::ST_BAD_COUNT;
            end else begin
              for (int i = 0; i < cnt; i++) begin
                prv[i] = (i == 0) ? prt_pkg::END_LINK : 13'(i - 1);
                nxt[i] = (i + 1 == cnt) ? prt_pkg::END_LINK : 13'(i + 1);
              end
              head    = '0;
              pending = 13'(cnt);
              total   = 13'(cnt);
              live    = 1;
            end
          end
        end
        prt_pkg::MODE_MARK: begin
          if (!live) r.status = prt_pkg::ST_NOT_START;
          else if (pkt_bytes == 0 || off % pkt_bytes != 0)
            r.status = prt_pkg::ST_MISALIGNED;
          else begin
            slot = off / pkt_bytes;
            if (slot >= total) r.status = prt_pkg::ST_RANGE;
            else begin
              nx = nxt[slot];
              pv = prv[slot];
              // a cleared entry has next link zero: already received
              if (nx != 0) begin
                prv[slot] = '0;
                nxt[slot] = '0;
                if (nx < total) prv[nx] = pv;
                if (pv >= total) head = nx;
                else nxt[pv] = nx;
                if (pending > 0) pending--;
                r.fresh = 1;
              end
            end
          end
        end
        prt_pkg::MODE_QUERY: begin
          if (!live) r.status = prt_pkg::ST_NOT_START;
          else if (eidx >= total) r.status = prt_pkg::ST_RANGE;
          else r.link = nxt[eidx];
        end
        default: ;
      endcase
      r.head    = head;
      r.pending = pending;
      r.percent = (total != 0 && pending <= total) ?
                  7'((32'(total - pending) * 100) / total) : 7'd0;
      r.done    = (pending == 0);
      awaited.push_back(r);
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tracker_result_t got);
      tracker_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d",
                 $time, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      field_check("status", want.status, got.status);
      field_check("newly_received", want.fresh, got.fresh);
      field_check("link_index", want.link, got.link);
      field_check("head_index", want.head, got.head);
      field_check("outstanding_count", want.pending, got.pending);
      field_check("progress_percent", want.percent, got.percent);
      field_check("all_received", want.done, got.done);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;

  tracker_scoreboard sb = new();

  // handshakes and output data sampled mid-cycle, stable up to the next edge
  logic        in_fire, out_fire;
  logic [47:0] out_data;
  logic [2:0]  out_user;
  bit          send_gaps, sink_gaps;
  int          items_sent;

  packet_receive_tracker dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    in_fire  = s_tvalid && s_tready;
    out_fire = m_tvalid && m_tready;
    out_data = m_tdata;
    out_user = m_tuser;
  end

  // receiver side: random back-pressure when enabled
  always @(posedge clk) begin
    m_tready <= !sink_gaps || ($urandom_range(99) >= 30);
  end

  // unpack and check every accepted result item
  always @(posedge clk) begin
    tracker_result_t got;
    if (!rst && out_fire) begin
      got.status  = prt_pkg::status_t'(out_user);
      got.fresh   = out_data[0];
      got.link    = out_data[13:1];
      got.head    = out_data[26:14];
      got.pending = out_data[39:27];
      got.percent = out_data[46:40];
      got.done    = out_data[47];
      sb.check_result(got);
    end
  end

  // one input item, with optional random gap before it
  task automatic send_item(prt_pkg::mode_t md, logic [31:0] off, logic [11:0] eidx);
    while (send_gaps && $urandom_range(99) < 30) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'b0, eidx, off};
    s_tuser  <= md;
    do @(posedge clk); while (!in_fire);
    sb.note_item(md, off, eidx);
    items_sent++;
  endtask

  // hold off until every result is back, then let the block settle
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(prt_pkg::reg_index_t idx, logic [31:0] value);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic setup(logic [15:0] pb, logic [31:0] fb);
    drain();
    write_reg(prt_pkg::REG_PACKET_BYTES, 32'(pb));
    write_reg(prt_pkg::REG_FILE_BYTES, fb);
  endtask

  // one random phase: new registers, a start, then mostly well-formed marks
  task automatic random_phase(int n_items, bit big);
    logic [15:0] pb;
    logic [31:0] fb;
    int cnt, pick, k;
    logic [11:0] eidx;
    logic [31:0] off;
    pick = $urandom_range(99);
    if (pick < 60) pb = 16'($urandom_range(1, 64));
    else if (pick < 70) pb = 16'd1;
    else if (pick < 78) pb = 16'hFFFF;
    else pb = 16'($urandom_range(1, 65535));
    cnt = big ? $urandom_range(3000, prt_pkg::MAX_PACKETS) : $urandom_range(1, 40);
    fb  = 32'((cnt - 1) * pb + $urandom_range(1, pb));
    pick = $urandom_range(99);
    // some phases get a count that the block must refuse
    if (!big && pick < 6) fb = 32'd0;
    else if (!big && pick < 12)
      fb = 32'(prt_pkg::MAX_PACKETS * pb + $urandom_range(1, pb));
    else if (!big && pick < 15) fb = $urandom;
    setup(pb, fb);
    send_item(prt_pkg::MODE_START, $urandom, 12'($urandom));
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      eidx = 12'($urandom_range(0, cnt + 2 > 4095 ? 4095 : cnt + 2));
      off  = 32'(eidx) * pb;
      if (pick < 60) send_item(prt_pkg::MODE_MARK, off, 12'($urandom));
      else if (pick < 78) send_item(prt_pkg::MODE_QUERY, $urandom, eidx);
      else if (pick < 84) send_item(prt_pkg::MODE_QUERY, $urandom, 12'($urandom));
      else if (pick < 90) send_item(prt_pkg::MODE_MARK, $urandom, 12'($urandom));
      else if (pick < 94)
        send_item(prt_pkg::MODE_MARK, off + (pb > 1 ? $urandom_range(1, pb - 1) : 0),
                  12'($urandom));
      else if (pick < 97) send_item(prt_pkg::MODE_NONE, $urandom, 12'($urandom));
      else send_item(prt_pkg::MODE_START, $urandom, 12'($urandom));
    end
  endtask

  initial begin
    int phase;
    rst       <= 1;
    cfg_we    <= 0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 0;
    s_tdata   <= '0;
    s_tuser   <= prt_pkg::MODE_NONE;
    send_gaps = 1;
    sink_gaps = 1;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // before any start, reset registers give a zero count
    send_item(prt_pkg::MODE_MARK, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_NONE, 32'hFFFF_FFFF, 12'hFFF);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);
    // zero packet size, a count far above capacity, then one just above it
    setup(16'd0, 32'd4096);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);
    setup(16'hFFFF, 32'hFFFF_FFFF);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);
    setup(16'd1, 32'd4097);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);
    // full capacity list
    setup(16'd1, 32'd4096);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'hFFF);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_MARK, 32'hFFFF_FFFF, 12'd0);
    send_item(prt_pkg::MODE_MARK, 32'd4095, 12'd0);
    send_item(prt_pkg::MODE_MARK, 32'd4095, 12'd0);
    send_item(prt_pkg::MODE_MARK, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'hFFF);
    // small list, misaligned mark, then packet size zeroed while started
    setup(16'd3, 32'd7);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_MARK, 32'd1, 12'd0);
    send_item(prt_pkg::MODE_MARK, 32'd3, 12'd0);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'd0);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'd3);
    setup(16'd0, 32'd7);
    send_item(prt_pkg::MODE_MARK, 32'd6, 12'd0);
    send_item(prt_pkg::MODE_QUERY, 32'd0, 12'd2);
    send_item(prt_pkg::MODE_START, 32'd0, 12'd0);

    // random phases; every tenth phase quiet on both sides, two large lists
    phase = 0;
    while (items_sent < 2000) begin
      send_gaps = (phase % 10 != 4);
      sink_gaps = (phase % 10 != 4);
      random_phase($urandom_range(20, 120), phase == 3 || phase == 15);
      phase++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/prt_pkg.sv
hdl/prt_ram.sv
hdl/packet_receive_tracker.sv
hdl/prt_checker.sv
bench/testbench.sv
